@@ rtl/bod_pkg.sv @@
package bod_pkg;

   localparam int unsigned PIXEL_W            = 8;
   localparam int unsigned LEVELS_W           = 9;
   localparam int unsigned ORDER_W            = 3;
   localparam int unsigned CSR_DATA_W         = 9;
   localparam int unsigned CSR_ADDR_W         = 1;
   localparam int unsigned MAX_ORDER_LOG2_DEF = 4;
   localparam int unsigned COORD_WIDTH_DEF    = 12;

   // fraction bits of the reciprocal used for the divide by step
   localparam int unsigned RECIP_SHIFT        = 18;
   localparam int unsigned RECIP_W            = RECIP_SHIFT + 1;

   // level numerator never exceeds 509
   localparam int unsigned QUOT_W             = 9;

   localparam logic [LEVELS_W-1:0] LEVELS_RESET = 9'd2;
   localparam logic [ORDER_W-1:0]  ORDER_RESET  = 3'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_OUTPUT_LEVELS = 1'b0,
      REG_MATRIX_ORDER  = 1'b1
   } csr_index_type;

endpackage

@@ rtl/bod_req_if.sv @@
interface bod_req_if #(
   parameter int unsigned COORD_WIDTH = bod_pkg::COORD_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic [bod_pkg::PIXEL_W-1:0]  pixel_in;
   logic [COORD_WIDTH-1:0]       row_pos;
   logic [COORD_WIDTH-1:0]       col_pos;

   modport source (output valid, output pixel_in, output row_pos, output col_pos,
                   input ready);
   modport sink   (input valid, input pixel_in, input row_pos, input col_pos,
                   output ready);
endinterface

@@ rtl/bod_rsp_if.sv @@
interface bod_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bod_pkg::PIXEL_W-1:0]  pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

@@ rtl/bayer_ordered_dither.sv @@
// bayer_ordered_dither: ordered dither of 8-bit grey pixels with a bayer threshold matrix
// the input transfer is registered through stages s1 to s4 before the result is offered on rsp_bus
// throughput: one pixel per cycle while rsp_bus.ready does not hold the output; stages are threshold lookup,
// scaled sum, reciprocal multiply for the divide by step, and final multiply by step
// reset: synchronous active high; clears all stage valid bits and loads
// output_levels = 2 and matrix_order_log2 = 3
module bayer_ordered_dither #(
   parameter int unsigned MAX_ORDER_LOG2 = bod_pkg::MAX_ORDER_LOG2_DEF,
   parameter int unsigned COORD_WIDTH    = bod_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   bod_req_if.sink                         req_bus,
   bod_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [bod_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bod_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned PW = bod_pkg::PIXEL_W;
   localparam int unsigned DW = 2 * MAX_ORDER_LOG2;          // threshold width
   localparam int unsigned KW = $clog2(MAX_ORDER_LOG2 + 1);  // clamped order width
   localparam int unsigned XW = PW + DW + 1;                 // scaled sum width
   localparam int unsigned RW = bod_pkg::RECIP_W;
   localparam int unsigned QW = bod_pkg::QUOT_W;
   localparam int unsigned PRODW = QW + RW;

   // ---------------------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------------------
   logic [bod_pkg::LEVELS_W-1:0] levels_ff;
   logic [bod_pkg::ORDER_W-1:0]  order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= bod_pkg::LEVELS_RESET;
         order_ff  <= bod_pkg::ORDER_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            bod_pkg::REG_OUTPUT_LEVELS: levels_ff <= csr_wdata;
            bod_pkg::REG_MATRIX_ORDER:  order_ff  <= csr_wdata[bod_pkg::ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped levels-1 (1..255) and clamped order (1..MAX_ORDER_LOG2)
   logic [PW-1:0] lmax_w;
   logic [KW-1:0] korder_w;

   always_comb begin
      if (levels_ff < 9'd2) begin
         lmax_w = 8'd1;
      end else if (levels_ff > 9'd256) begin
         lmax_w = 8'd255;
      end else begin
         lmax_w = 8'(levels_ff - 9'd1);
      end
      if (order_ff == 3'd0) begin
         korder_w = KW'(1);
      end else if (int'(order_ff) > int'(MAX_ORDER_LOG2)) begin
         korder_w = KW'(MAX_ORDER_LOG2);
      end else begin
         korder_w = KW'(order_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // step = 255 div (levels-1) and its rounded-up reciprocal, as constant tables by levels-1
   // ---------------------------------------------------------------------------------------
   logic [PW-1:0] step_tab [256];
   logic [RW-1:0] recip_tab [256];

   for (genvar gi = 0; gi < 256; gi++) begin : g_step_tab
      localparam int unsigned StepVal  = 255 / ((gi == 0) ? 1 : gi);
      localparam int unsigned RecipVal =
         ((1 << bod_pkg::RECIP_SHIFT) + StepVal - 1) / StepVal;
      assign step_tab[gi]  = PW'(StepVal);
      assign recip_tab[gi] = RW'(RecipVal);
   end

   // ---------------------------------------------------------------------------------------
   // stage handshake: each stage loads when it is empty or the next one moves on
   // ---------------------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   assign s4_ready = !s4_valid_ff || rsp_bus.ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign req_bus.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 1: bayer threshold from the low coordinate bits, step lookup
   // ---------------------------------------------------------------------------------------
   logic [DW-1:0] thresh_in;

   // row/col bit 0 gives the most significant base-4 digit
   always_comb begin
      thresh_in = '0;
      for (int b = 0; b < MAX_ORDER_LOG2; b++) begin
         if (b < int'(korder_w)) begin
            unique case ({req_bus.row_pos[b], req_bus.col_pos[b]})
               2'b00:   thresh_in = (thresh_in << 2) | DW'(0);
               2'b01:   thresh_in = (thresh_in << 2) | DW'(2);
               2'b10:   thresh_in = (thresh_in << 2) | DW'(3);
               default: thresh_in = (thresh_in << 2) | DW'(1);
            endcase
         end
      end
   end

   logic [PW-1:0] s1_pixel_ff;
   logic [DW-1:0] s1_thresh_ff;
   logic [KW-1:0] s1_order_ff;
   logic [PW-1:0] s1_lmax_ff;
   logic [PW-1:0] s1_step_ff;
   logic [RW-1:0] s1_recip_ff;

   always_ff @(posedge clock) begin
      if (s1_ready && req_bus.valid) begin
         s1_pixel_ff  <= req_bus.pixel_in;
         s1_thresh_ff <= thresh_in;
         s1_order_ff  <= korder_w;
         s1_lmax_ff   <= lmax_w;
         s1_step_ff   <= step_tab[lmax_w];
         s1_recip_ff  <= recip_tab[lmax_w];
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 2: q = (pixel*R*R + step*D) >> 2k, which is the dividend over step alone
   // ---------------------------------------------------------------------------------------
   logic [XW-1:0] sum_in;
   logic [QW-1:0] quot_in;

   assign sum_in  = (XW'(s1_pixel_ff) << (2 * s1_order_ff))
                  + (XW'(s1_step_ff) * XW'(s1_thresh_ff));
   assign quot_in = QW'(sum_in >> (2 * s1_order_ff));

   logic [QW-1:0] s2_quot_ff;
   logic [PW-1:0] s2_lmax_ff;
   logic [PW-1:0] s2_step_ff;
   logic [RW-1:0] s2_recip_ff;

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_quot_ff  <= quot_in;
         s2_lmax_ff  <= s1_lmax_ff;
         s2_step_ff  <= s1_step_ff;
         s2_recip_ff <= s1_recip_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 3: level = q div step by reciprocal multiply (exact for q < 512), clamp
   // ---------------------------------------------------------------------------------------
   logic [PRODW-1:0] recip_prod;
   logic [QW:0]      level_raw;
   logic [PW-1:0]    level_in;

   assign recip_prod = PRODW'(s2_quot_ff) * PRODW'(s2_recip_ff);
   assign level_raw  = (QW + 1)'(recip_prod >> bod_pkg::RECIP_SHIFT);
   assign level_in   = (level_raw > (QW + 1)'(s2_lmax_ff)) ? s2_lmax_ff
                                                            : PW'(level_raw);

   logic [PW-1:0] s3_level_ff;
   logic [PW-1:0] s3_step_ff;

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_level_ff <= level_in;
         s3_step_ff  <= s2_step_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stage 4: output = level * step, held until the result transfer
   // ---------------------------------------------------------------------------------------
   logic [2*PW-1:0] out_prod;
   logic [PW-1:0]   s4_pixel_ff;

   assign out_prod = s3_level_ff * s3_step_ff;

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_pixel_ff <= out_prod[PW-1:0];
      end
   end

   assign rsp_bus.valid     = s4_valid_ff;
   assign rsp_bus.pixel_out = s4_pixel_ff;

endmodule

@@ tb/dither_checker.sv @@
`timescale 1ns / 100ps

module dither_checker
   import bod_pkg::*;
#(
   parameter int unsigned COORD_W = COORD_WIDTH_DEF,
   parameter int unsigned MAX_K   = MAX_ORDER_LOG2_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel,
   input  logic [COORD_W-1:0]    req_row,
   input  logic [COORD_W-1:0]    req_col,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [PIXEL_W-1:0]    rsp_pixel,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           error_count,
   output int unsigned           pending_count,
   output int unsigned           result_count
);

   typedef struct {
      logic [PIXEL_W-1:0]  pixel;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [LEVELS_W-1:0] levels;
      logic [ORDER_W-1:0]  order;
      logic [PIXEL_W-1:0]  dithered;
   } dither_expect_t;

   dither_expect_t       expected_q[$];
   logic [LEVELS_W-1:0]  levels_q;
   logic [ORDER_W-1:0]   order_q;

   // recursive bayer value, one quadrant offset per coordinate bit
   function automatic int unsigned bayer_threshold(int unsigned k,
                                                   logic [COORD_W-1:0] row,
                                                   logic [COORD_W-1:0] col);
      int unsigned d;
      d = 0;
      for (int b = 0; b < k; b++) begin
         case ({row[b], col[b]})
            2'b00:   d = d * 4;
            2'b01:   d = d * 4 + 2;
            2'b10:   d = d * 4 + 3;
            default: d = d * 4 + 1;
         endcase
      end
      return d;
   endfunction

   function automatic logic [PIXEL_W-1:0] dither_pixel(logic [PIXEL_W-1:0]  pixel,
                                                       logic [COORD_W-1:0]  row,
                                                       logic [COORD_W-1:0]  col,
                                                       logic [LEVELS_W-1:0] levels_raw,
                                                       logic [ORDER_W-1:0]  order_raw);
      int unsigned lv, k, step, area, level;
      lv = levels_raw;
      if (lv < 2) lv = 2;
      if (lv > 256) lv = 256;
      k = order_raw;
      if (k < 1) k = 1;
      if (k > MAX_K) k = MAX_K;
      step  = 255 / (lv - 1);
      area  = 1 << (2 * k);
      level = (pixel * area + step * bayer_threshold(k, row, col)) / (step * area);
      if (level > lv - 1) level = lv - 1;
      return PIXEL_W'(level * step);
   endfunction

   always_ff @(posedge clock) begin : monitor
      dither_expect_t head;
      dither_expect_t fresh;
      int unsigned    errs;
      errs = error_count;
      if (reset) begin
         levels_q      <= LEVELS_RESET;
         order_q       <= ORDER_RESET;
         expected_q.delete();
         error_count   <= 0;
         pending_count <= 0;
         result_count  <= 0;
      end else begin
         // retire first: a result never belongs to the item accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               if (errs < 10)
                  $display("[%0t] unexpected result pixel_out=%0d, nothing pending",
                           $realtime, rsp_pixel);
               errs++;
            end else begin
               head = expected_q.pop_front();
               if (rsp_pixel !== head.dithered) begin
                  if (errs < 10)
                     $display("[%0t] mismatch pixel=%0d row=%0d col=%0d levels=%0d order=%0d: expected %0d, got %0d",
                              $realtime, head.pixel, head.row, head.col, head.levels,
                              head.order, head.dithered, rsp_pixel);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            fresh.pixel    = req_pixel;
            fresh.row      = req_row;
            fresh.col      = req_col;
            fresh.levels   = levels_q;
            fresh.order    = order_q;
            fresh.dithered = dither_pixel(req_pixel, req_row, req_col, levels_q, order_q);
            expected_q.push_back(fresh);
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               REG_OUTPUT_LEVELS: levels_q <= csr_wdata[LEVELS_W-1:0];
               REG_MATRIX_ORDER:  order_q  <= csr_wdata[ORDER_W-1:0];
               default: ;
            endcase
         end
         error_count   <= errs;
         pending_count <= expected_q.size();
      end
   end

endmodule

@@ tb/bayer_ordered_dither_test.sv @@
`timescale 1ns / 100ps

module bayer_ordered_dither_test;
   import bod_pkg::*;

   localparam int unsigned COORD_W          = COORD_WIDTH_DEF;
   localparam int unsigned PIPE_LATENCY     = 4;
   localparam int unsigned LONG_HOLD_CYCLES = 120;
   localparam int unsigned RANDOM_PHASES    = 10;
   localparam int unsigned ITEMS_PER_PHASE  = 80;
   localparam int unsigned FLOOD_ITEMS      = 60;
   localparam int unsigned TIMEOUT_NS       = 3_000_000;

   // receiver stall patterns
   localparam int unsigned RX_ALWAYS   = 0;
   localparam int unsigned RX_COIN     = 1;
   localparam int unsigned RX_SPARSE   = 2;
   localparam int unsigned RX_PERIODIC = 3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  long_hold_go;

   int unsigned           error_count;
   int unsigned           pending_count;
   int unsigned           result_count;
   int unsigned           items_sent;
   int unsigned           settings_done;
   int unsigned           burst_left;
   logic [COORD_W-1:0]    scan_row;
   logic [COORD_W-1:0]    scan_col;

   bod_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   bod_rsp_if                          rsp_bus ();

   bayer_ordered_dither #(
      .MAX_ORDER_LOG2 (MAX_ORDER_LOG2_DEF),
      .COORD_WIDTH    (COORD_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // scoreboard sits beside the block and only watches its ports
   dither_checker #(
      .COORD_W (COORD_W),
      .MAX_K   (MAX_ORDER_LOG2_DEF)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_pixel     (req_bus.pixel_in),
      .req_row       (req_bus.row_pos),
      .req_col       (req_bus.col_pos),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_pixel     (rsp_bus.pixel_out),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog for a hung handshake
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results still pending", pending_count);
      $display("bayer_ordered_dither verification failed");
      $finish;
   end

   // one transfer on req_bus; valid stays up so back-to-back items need no extra step
   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel,
                             input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col);
      req_bus.valid    <= 1'b1;
      req_bus.pixel_in <= pixel;
      req_bus.row_pos  <= row;
      req_bus.col_pos  <= col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // drop valid and wait until every expected transfer on rsp_bus has arrived
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // both registers written on consecutive edges, write enable held high across them
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] levels,
                                input logic [CSR_DATA_W-1:0] order);
      csr_we    <= 1'b1;
      csr_addr  <= REG_OUTPUT_LEVELS;
      csr_wdata <= levels;
      @(posedge clock);
      csr_addr  <= REG_MATRIX_ORDER;
      csr_wdata <= order;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      settings_done++;
   endtask

   // bursty sender: random gaps between bursts, some bursts without any gap
   task automatic send_random_pixel(input bit no_gap);
      logic [PIXEL_W-1:0] pixel;
      int unsigned        gap;
      if (!no_gap && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left != 0) burst_left--;
      case ($urandom_range(0, 7))
         0:       pixel = '0;
         1:       pixel = '1;
         2:       pixel = PIXEL_W'($urandom_range(0, 15));
         3:       pixel = PIXEL_W'($urandom_range(240, 255));
         default: pixel = PIXEL_W'($urandom);
      endcase
      // mostly a raster walk, sometimes a jump anywhere in the frame
      if ($urandom_range(0, 3) == 0) begin
         scan_row = COORD_W'($urandom);
         scan_col = COORD_W'($urandom);
      end else begin
         scan_col = scan_col + COORD_W'(1);
         if (scan_col == '0 || $urandom_range(0, 31) == 0) scan_row = scan_row + COORD_W'(1);
      end
      send_pixel(pixel, scan_row, scan_col);
   endtask

   // receiver: random stall patterns, plus one long hold-off requested by the sender
   initial begin : rsp_side
      int unsigned pattern;
      int unsigned left;
      bit          hold_taken;
      pattern    = RX_ALWAYS;
      left       = 0;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold_go && !hold_taken) begin
            // count out the hold here while the sender keeps offering
            hold_taken = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (left == 0) begin
               pattern = $urandom_range(RX_ALWAYS, RX_PERIODIC);
               left    = $urandom_range(16, 64);
            end
            left--;
            case (pattern)
               RX_ALWAYS: rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_bus.ready <= (left % 3 == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin : req_side
      logic [CSR_DATA_W-1:0] levels;
      logic [CSR_DATA_W-1:0] order;

      items_sent    = 0;
      settings_done = 0;
      burst_left    = 0;
      scan_row      = '0;
      scan_col      = '0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.pixel_in <= '0;
      req_bus.row_pos  <= '0;
      req_bus.col_pos  <= '0;
      csr_we           <= 1'b0;
      csr_addr         <= REG_OUTPUT_LEVELS;
      csr_wdata        <= '0;
      long_hold_go     <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: two levels, 8x8 matrix
      send_pixel(8'd0,   12'd0,    12'd0);
      send_pixel(8'd255, 12'd0,    12'd0);
      send_pixel(8'd255, 12'hfff,  12'hfff);
      send_pixel(8'd128, 12'd0,    12'd1);
      send_pixel(8'd1,   12'd1,    12'd0);
      send_pixel(8'd254, 12'd7,    12'd7);
      send_pixel(8'd127, 12'haaa,  12'h555);
      send_pixel(8'd64,  12'h555,  12'haaa);
      drain_results();

      // too few levels and order too small: clamp to 2 levels, 2x2 matrix
      apply_setting(9'd0, 9'd0);
      send_pixel(8'd0,   12'd0,   12'd0);
      send_pixel(8'd255, 12'd1,   12'd1);
      send_pixel(8'd96,  12'd1,   12'd0);
      send_pixel(8'd160, 12'd0,   12'd1);
      drain_results();

      // too many levels and order too large: clamp to 256 levels, 16x16 matrix
      apply_setting(9'd511, 9'd7);
      send_pixel(8'd0,   12'hfff, 12'hfff);
      send_pixel(8'd255, 12'h00f, 12'h0f0);
      send_pixel(8'd1,   12'h80f, 12'h7f0);
      send_pixel(8'd200, 12'h123, 12'h321);
      drain_results();

      // exact upper limits
      apply_setting(9'd256, 9'd4);
      send_pixel(8'd0,   12'd15,  12'd0);
      send_pixel(8'd255, 12'd0,   12'd15);
      send_pixel(8'd17,  12'hff0, 12'h00f);
      send_pixel(8'd238, 12'h5a5, 12'ha5a);
      drain_results();

      // just over the level limit; order written with high data bits set (low bits 5)
      apply_setting(9'd257, 9'h1fd);
      send_pixel(8'd0,   12'd3,   12'd5);
      send_pixel(8'd255, 12'hfff, 12'd0);
      send_pixel(8'd99,  12'h777, 12'h888);
      drain_results();

      // random phases, each under a setting of its own
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin levels = 9'd2;   order = 9'd1; end
            1: begin levels = 9'd256; order = 9'd4; end
            2: begin levels = 9'd3;   order = 9'd2; end
            default: begin
               case ($urandom_range(0, 5))
                  0:       levels = CSR_DATA_W'($urandom_range(0, 1));
                  1:       levels = CSR_DATA_W'($urandom_range(2, 5));
                  2:       levels = CSR_DATA_W'($urandom_range(6, 64));
                  3:       levels = CSR_DATA_W'($urandom_range(65, 256));
                  4:       levels = CSR_DATA_W'($urandom_range(257, 511));
                  default: levels = 9'd256;
               endcase
               if ($urandom_range(0, 3) == 0) order = CSR_DATA_W'($urandom_range(0, 511));
               else                           order = CSR_DATA_W'($urandom_range(1, 4));
            end
         endcase
         apply_setting(levels, order);
         if (phase == 3) begin
            // long receiver hold-off while items keep coming back to back
            long_hold_go <= 1'b1;
            for (int i = 0; i < FLOOD_ITEMS; i++) send_random_pixel(1'b1);
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_pixel(1'b0);
         drain_results();
      end

      repeat (PIPE_LATENCY * 4) @(posedge clock);
      $display("run covered %0d pixels under %0d written settings plus the reset setting",
               items_sent, settings_done);
      $display("%0d results checked, %0d errors, %0d left pending",
               result_count, error_count, pending_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("bayer_ordered_dither verification clean");
      end else begin
         $display("bayer_ordered_dither verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bod_pkg.sv
rtl/bod_req_if.sv
rtl/bod_rsp_if.sv
rtl/bayer_ordered_dither.sv
tb/dither_checker.sv
tb/bayer_ordered_dither_test.sv
